FILE: src/bps_pkg.sv
// Shared types, constants and the arctangent table for the ballistic pitch solver.
`timescale 1ns / 1ps
`default_nettype none
package bps_pkg;

    localparam int DIST_W      = 23;
    localparam int HGT_W       = 24;
    localparam int SPEED_W     = 14;
    localparam int TOL_W       = 16;
    localparam int PASS_W      = 6;
    localparam int PITCH_W     = 18;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 48;

    localparam int GRAV_W      = 20;
    localparam logic [GRAV_W-1:0] GRAV_Q16 = 20'd642253;
    localparam int SQ_W        = 31;   // (d*d + aim*aim) >> 16
    localparam int VSQ_W       = 28;
    localparam int DEN_W       = 29;   // 2*v*v
    localparam int NUM_W       = 52;   // s*g + v*v
    localparam int DIV_STEPS   = NUM_W;
    localparam int MISS_W      = 54;
    localparam int CNT_W       = 6;
    localparam int IDX_W       = 5;
    localparam int COR_W       = 43;
    localparam int ANG_W       = 19;
    localparam int ATAN_W      = 16;

    localparam int DEFAULT_ANGLE_ITERATIONS = 18;
    localparam int ATAN_LEN    = 24;

    localparam logic signed [HGT_W-1:0] AIM_MAX = 24'sh7FFFFF;
    localparam logic signed [HGT_W-1:0] AIM_MIN = -24'sh800000;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 19'sd102944;
    localparam logic [PASS_W-1:0] PASS_CAP = 6'd32;

    localparam logic [SPEED_W-1:0] SPEED_RESET = 14'd3840;
    localparam logic [TOL_W-1:0]   TOL_RESET   = 16'd7;
    localparam logic [PASS_W-1:0]  PASSES_RESET = 6'd20;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PASSES = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SCALE,
        ST_MULT,
        ST_DIV,
        ST_UPDATE,
        ST_CINIT,
        ST_COR
    } state_t;

    typedef struct packed {
        logic             load_item;
        logic             square;
        logic             scale;
        logic             mult;
        logic             div_step;
        logic             update;
        logic             cor_init;
        logic             cor_step;
        logic [IDX_W-1:0] cor_idx;
        logic             out_load;
    } cmd_t;

    typedef struct packed {
        logic              hit;
        logic              last_pass;
        logic [PASS_W-1:0] limit;
    } status_t;

    function automatic logic [ATAN_W-1:0] atan_q16(input logic [IDX_W-1:0] idx);
        logic [ATAN_W-1:0] r;
        case (idx)
            5'd0:    r = 16'd51472;
            5'd1:    r = 16'd30385;
            5'd2:    r = 16'd16055;
            5'd3:    r = 16'd8150;
            5'd4:    r = 16'd4091;
            5'd5:    r = 16'd2047;
            5'd6:    r = 16'd1024;
            5'd7:    r = 16'd512;
            5'd8:    r = 16'd256;
            5'd9:    r = 16'd128;
            5'd10:   r = 16'd64;
            5'd11:   r = 16'd32;
            5'd12:   r = 16'd16;
            5'd13:   r = 16'd8;
            5'd14:   r = 16'd4;
            5'd15:   r = 16'd2;
            5'd16:   r = 16'd1;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: src/ballistic_pitch_solver.sv
// Top level of the drag-free ballistic pitch solver.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    tdata: horizontal_distance, target_height
//  m_*       out  m_tvalid/m_tready    tdata: pitch_angle, aim_height, passes_used;
//                                      tuser: converged
//  cfg_*     in   cfg_we               cfg_index, cfg_data (no read-back)
//
// Each item runs from 1 to 32 passes of the pass loop.
// Each pass runs the 52-step restoring divider (one quotient bit a cycle).
// One item is in flight at a time; the result register lets the next item be
// accepted while the previous result waits. Reset restores register defaults
// and leaves the block idle; a stalled output holds the sequencer at its last step.
`timescale 1ns / 1ps
`default_nettype none
module ballistic_pitch_solver #(
    parameter int ANGLE_ITERATIONS = bps_pkg::DEFAULT_ANGLE_ITERATIONS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [22:0] horizontal_distance, [46:23] target_height, [47] zero
    input  wire logic [bps_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [17:0] pitch_angle, [41:18] aim_height, [47:42] passes_used
    output logic [bps_pkg::OUT_DATA_W-1:0]         m_tdata,
    // [0] converged
    output logic                                   m_tuser,
    input  wire logic                              cfg_we,
    input  wire logic [bps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bps_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bps_pkg::*;

    cmd_t                       cmd;
    status_t                    status;
    logic                       busy;
    logic                       out_free;
    logic                       m_valid_reg;
    logic signed [PITCH_W-1:0]  pitch_angle;
    logic signed [HGT_W-1:0]    aim_height;
    logic [PASS_W-1:0]          passes_used;
    logic                       converged;

    assign out_free = !m_valid_reg || m_tready;

    bps_ctrl #(
        .ANGLE_ITERATIONS(ANGLE_ITERATIONS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    bps_datapath u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .horizontal_distance (s_tdata[DIST_W-1:0]),
        .target_height       ($signed(s_tdata[DIST_W+HGT_W-1:DIST_W])),
        .cmd                 (cmd),
        .status              (status),
        .pitch_angle         (pitch_angle),
        .aim_height          (aim_height),
        .passes_used         (passes_used),
        .converged           (converged)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (cmd.out_load)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {passes_used, aim_height, pitch_angle};
    assign m_tuser  = converged;

    // accept only when idle, so the next cycle is busy
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> busy && !s_tready)
        else $error("item accepted while another is in flight");

    a_pass_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> passes_used != '0 && passes_used <= PASS_CAP)
        else $error("pass count out of range");

    a_limit_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> passes_used == status.limit)
        else $error("unconverged result stopped before the pass limit");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !m_valid_reg || m_tready)
        else $error("result register overwritten");

endmodule
`default_nettype wire

FILE: src/bps_ctrl.sv
// Sequencer for the pass loop, the divider steps and the CORDIC steps.
`timescale 1ns / 1ps
`default_nettype none
module bps_ctrl #(
    parameter int ANGLE_ITERATIONS = bps_pkg::DEFAULT_ANGLE_ITERATIONS
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic            out_free,
    input  wire bps_pkg::status_t status,
    output bps_pkg::cmd_t        cmd,
    output logic                 busy
);
    import bps_pkg::*;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);
    // count of the cycle after the last rotation
    localparam logic [CNT_W-1:0] COR_LAST = CNT_W'(ANGLE_ITERATIONS);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              cor_last;

    assign cor_last = (cnt_reg == COR_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_MULT;
            ST_MULT:   state_next = ST_DIV;
            ST_DIV:    if (cnt_reg == DIV_LAST) state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                if (status.hit || status.last_pass) state_next = ST_CINIT;
                else state_next = ST_SQUARE;
            end
            ST_CINIT:  state_next = ST_COR;
            ST_COR:    if (cor_last && out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
        // restart the step count on every state change
        cnt_next = (state_next != state_reg) ? '0 :
                   ((state_reg == ST_COR && cor_last) ? cnt_reg : cnt_reg + 1'b1);
    end

    always_comb
    begin
        cmd          = '0;
        cmd.cor_idx  = cnt_reg[IDX_W-1:0];
        in_ready     = 1'b0;
        busy         = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                busy          = 1'b0;
                cmd.load_item = in_valid;
            end
            ST_SQUARE: cmd.square   = 1'b1;
            ST_SCALE:  cmd.scale    = 1'b1;
            ST_MULT:   cmd.mult     = 1'b1;
            ST_DIV:    cmd.div_step = 1'b1;
            ST_UPDATE: cmd.update   = 1'b1;
            ST_CINIT:  cmd.cor_init = 1'b1;
            ST_COR:
            begin
                // hold after the last step until the output register is free
                cmd.cor_step = !cor_last;
                cmd.out_load = cor_last && out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: src/bps_datapath.sv
// Config registers, square/scale/multiply, restoring divider, aim update and CORDIC.
`timescale 1ns / 1ps
`default_nettype none
module bps_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [bps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bps_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [bps_pkg::DIST_W-1:0]       horizontal_distance,
    input  wire logic signed [bps_pkg::HGT_W-1:0] target_height,
    input  wire bps_pkg::cmd_t                    cmd,
    output bps_pkg::status_t                      status,
    output logic signed [bps_pkg::PITCH_W-1:0]    pitch_angle,
    output logic signed [bps_pkg::HGT_W-1:0]      aim_height,
    output logic [bps_pkg::PASS_W-1:0]            passes_used,
    output logic                                  converged
);
    import bps_pkg::*;

    logic [SPEED_W-1:0] speed_reg;
    logic [TOL_W-1:0]   tol_reg;
    logic [PASS_W-1:0]  passes_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg      <= SPEED_RESET;
            tol_reg        <= TOL_RESET;
            passes_cfg_reg <= PASSES_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SPEED:  speed_reg      <= cfg_data[SPEED_W-1:0];
                REG_TOL:    tol_reg        <= cfg_data[TOL_W-1:0];
                REG_PASSES: passes_cfg_reg <= cfg_data[PASS_W-1:0];
                default:    ;
            endcase
        end
    end

    logic [SPEED_W-1:0] v_eff;
    logic [VSQ_W-1:0]   vsq;
    logic [DEN_W-1:0]   den;
    logic [PASS_W-1:0]  limit;

    assign v_eff = (speed_reg == '0) ? SPEED_W'(1) : speed_reg;
    assign vsq   = v_eff * v_eff;
    assign den   = {vsq, 1'b0};
    assign limit = (passes_cfg_reg == '0) ? PASS_W'(1) :
                   ((passes_cfg_reg > PASS_CAP) ? PASS_CAP : passes_cfg_reg);

    // pass loop state
    logic [DIST_W-1:0]        d_reg;
    logic signed [HGT_W-1:0]  h_reg;
    logic signed [HGT_W-1:0]  aim_reg;
    logic signed [HGT_W-1:0]  eval_reg;
    logic [PASS_W-1:0]        pass_reg;
    logic                     conv_reg;
    logic [2*DIST_W-1:0]      dsq_reg;
    logic [2*HGT_W-2:0]       asq_reg;
    logic [SQ_W-1:0]          s_reg;
    logic [NUM_W-1:0]         quo_reg;
    logic [DEN_W-1:0]         rem_reg;

    logic signed [2*HGT_W-1:0] asq_full;
    logic [2*HGT_W-1:0]        sq_sum;
    logic [DEN_W:0]            rem_try;
    logic                      q_bit;
    logic signed [MISS_W-1:0]  drop_s;
    logic signed [MISS_W-1:0]  miss;
    logic [MISS_W-1:0]         mag;
    logic signed [MISS_W-1:0]  aim_raw;
    logic signed [HGT_W-1:0]   aim_sat;

    assign asq_full = aim_reg * aim_reg;
    assign sq_sum   = (2*HGT_W)'(dsq_reg) + (2*HGT_W)'(asq_reg);
    assign rem_try  = {rem_reg, quo_reg[NUM_W-1]};
    assign q_bit    = (rem_try >= {1'b0, den});
    assign drop_s   = $signed({2'b00, quo_reg});
    assign miss     = MISS_W'(h_reg) - MISS_W'(aim_reg) + drop_s;
    assign mag      = miss[MISS_W-1] ? MISS_W'(-miss) : MISS_W'(miss);
    assign aim_raw  = MISS_W'(h_reg) + drop_s;
    assign aim_sat  = (aim_raw > MISS_W'(AIM_MAX)) ? AIM_MAX :
                      ((aim_raw < MISS_W'(AIM_MIN)) ? AIM_MIN : aim_raw[HGT_W-1:0]);

    assign status.hit       = (mag <= MISS_W'(tol_reg));
    assign status.last_pass = ((pass_reg + 1'b1) == limit);
    assign status.limit     = limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_reg <= '0;
            conv_reg <= 1'b0;
        end
        else if (cmd.load_item)
        begin
            pass_reg <= '0;
            conv_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            pass_reg <= pass_reg + 1'b1;
            conv_reg <= status.hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            d_reg   <= horizontal_distance;
            h_reg   <= target_height;
            aim_reg <= target_height;
        end
        if (cmd.square)
        begin
            dsq_reg <= d_reg * d_reg;
            asq_reg <= asq_full[2*HGT_W-2:0];
        end
        if (cmd.scale)
            s_reg <= sq_sum[SQ_W+15:16];
        if (cmd.mult)
        begin
            // round half up: divide (s*g + v*v) by 2*v*v
            quo_reg <= NUM_W'(s_reg) * NUM_W'(GRAV_Q16) + NUM_W'(vsq);
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], q_bit};
            rem_reg <= q_bit ? DEN_W'(rem_try - {1'b0, den}) : rem_try[DEN_W-1:0];
        end
        if (cmd.update)
        begin
            eval_reg <= aim_reg;
            aim_reg  <= aim_sat;
        end
    end

    // CORDIC, vectoring mode, one rotation per cycle
    logic signed [COR_W-1:0] cx_reg, cy_reg;
    logic signed [ANG_W-1:0] z_reg;
    logic                    origin_reg;
    logic signed [COR_W-1:0] dx, dy;
    logic signed [ANG_W-1:0] step_ang;
    logic signed [ANG_W-1:0] z_clamped;

    assign dx       = cy_reg >>> cmd.cor_idx;
    assign dy       = cx_reg >>> cmd.cor_idx;
    assign step_ang = $signed({{(ANG_W-ATAN_W){1'b0}}, atan_q16(cmd.cor_idx)});
    assign z_clamped = (z_reg > HALF_PI_Q16) ? HALF_PI_Q16 :
                       ((z_reg < -HALF_PI_Q16) ? -HALF_PI_Q16 : z_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.cor_init)
        begin
            cx_reg     <= $signed({{(COR_W-DIST_W-16){1'b0}}, d_reg, 16'd0});
            cy_reg     <= $signed({{(COR_W-HGT_W-16){eval_reg[HGT_W-1]}}, eval_reg, 16'd0});
            z_reg      <= '0;
            origin_reg <= (d_reg == '0) && (eval_reg == '0);
        end
        else if (cmd.cor_step)
        begin
            if (cy_reg > 0)
            begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                z_reg  <= z_reg + step_ang;
            end
            else
            begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                z_reg  <= z_reg - step_ang;
            end
        end
        if (cmd.out_load)
        begin
            pitch_angle <= origin_reg ? '0 : z_clamped[PITCH_W-1:0];
            aim_height  <= eval_reg;
            passes_used <= pass_reg;
            converged   <= conv_reg;
        end
    end

endmodule
`default_nettype wire
